// ----- rtl/rbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared codes and types for the ring buffer deque: command and status codes,
// and the per-cycle shift control that the top level broadcasts to the cells.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // What the cell row does at a clock edge. A pop from the back only moves
  // the count, so the cells hold.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [WORD_W-1:0] push_value;
  } cell_ctrl_t;

endpackage

// ----- rtl/ring_buffer_deque_top.sv -----
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Double-ended queue of signed 32-bit words, capacity DEPTH.
//
// Commands enter on cmd/push_value and are taken at a clock edge with start
// high and busy low. Each command gives exactly one result, shown on status,
// count, is_empty, front_word and back_word for one cycle while done is high.
// The cell row and the count update at the accept edge, and the result
// registers load from them after that, as done rises. busy is high from the
// accept until done rises, so a new command waits for the last one's result;
// the next one may be taken in the same cycle that done is high.
// Storage is a row of DEPTH cells with the front element in cell 0. A front
// push or pop shifts the whole row by one; a back push writes the cell at
// the count. The back word is picked by the cell holding the last element
// and passed down the row, which sets the length of the result path.
// Reset empties the deque and clears busy and done; cell contents are left
// as they are and never show while empty. The receiver cannot stall.
// ----------------------------------------------------------------------------
module ring_buffer_deque_top
  import rbd_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     busy,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         count,
  output logic                     is_empty,
  output logic signed [WORD_W-1:0] front_word,
  output logic signed [WORD_W-1:0] back_word
);

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;
  logic [STAT_W-1:0]        stat_next;
  logic [STAT_W-1:0]        stat_pend;
  logic                     pend;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic signed [WORD_W-1:0] back_chain [DEPTH+1];

  assign accept = start && !busy;
  assign full   = (fill == CNT_W'(DEPTH));
  assign empty  = (fill == '0);
  assign busy   = pend;

  always_comb begin
    ctrl.op         = OP_HOLD;
    ctrl.push_value = push_value;
    fill_next       = fill;
    stat_next       = ST_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          stat_next = ST_FULL;
        end else begin
          ctrl.op   = OP_PUSH_FRONT;
          fill_next = fill + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          stat_next = ST_FULL;
        end else begin
          ctrl.op   = OP_PUSH_BACK;
          fill_next = fill + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          stat_next = ST_EMPTY;
        end else begin
          ctrl.op   = OP_POP_FRONT;
          fill_next = fill - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          stat_next = ST_EMPTY;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      default: ;
    endcase
    // cells move only on an accepted command
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end
  end

  assign back_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_word;
    logic signed [WORD_W-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = push_value;
    end else begin : g_mid
      assign prev_word = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_data[i];
    end else begin : g_inner
      assign next_word = cell_data[i+1];
    end

    rbd_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (fill),
      .from_prev (prev_word),
      .from_next (next_word),
      .back_in   (back_chain[i]),
      .data      (cell_data[i]),
      .back_out  (back_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= pend;
      pend <= accept;
      if (accept) begin
        fill      <= fill_next;
        stat_pend <= stat_next;
      end
    end
    // cells have settled by now: capture the result
    if (pend) begin
      status     <= stat_pend;
      count      <= fill;
      is_empty   <= empty;
      front_word <= empty ? '0 : cell_data[0];
      back_word  <= back_chain[DEPTH];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= CNT_W'(DEPTH)))
    else $error("count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (front_word == '0 && back_word == '0))
    else $error("words not zero while empty");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy ##1 done))
    else $error("accepted item did not give a result two cycles later");

endmodule

// ----- rtl/rbd_cell.sv -----
// ----------------------------------------------------------------------------
// rbd_cell
// One slot of the deque. Slot IDX holds the element at distance IDX from the
// front. It takes its neighbor's word on a front push or front pop, captures
// the pushed word on a back push aimed at it, and folds its word into the
// back-word chain when it holds the last element.
// ----------------------------------------------------------------------------
module rbd_cell
  import rbd_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic [CNT_W-1:0]         count,
  input  logic signed [WORD_W-1:0] from_prev,
  input  logic signed [WORD_W-1:0] from_next,
  input  logic signed [WORD_W-1:0] back_in,
  output logic signed [WORD_W-1:0] data,
  output logic signed [WORD_W-1:0] back_out
);

  logic is_last;

  assign is_last  = (count == CNT_W'(IDX + 1));
  assign back_out = is_last ? data : back_in;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_PUSH_FRONT: data <= from_prev;
      OP_PUSH_BACK: begin
        if (count == CNT_W'(IDX)) begin
          data <= ctrl.push_value;
        end
      end
      OP_POP_FRONT:  data <= from_next;
      default: ;
    endcase
  end

endmodule
